[hdl/frd_pkg.sv]
// Frame rate decimator: shared types and constants.
// Word types for the frame and decision channels, the register write
// bundle and the register index codes. No dependencies.
package frd_pkg;

  localparam int unsigned FpsW   = 7;
  localparam int unsigned MaxFps = 120;
  localparam int unsigned IdxW   = 8;

  localparam logic [FpsW-1:0] CaptureFpsRst = FpsW'(30);
  localparam logic [FpsW-1:0] RecordFpsRst  = FpsW'(30);

  typedef enum logic [IdxW-1:0] {
    RegCaptureFps = 8'd0,
    RegRecordFps  = 8'd1
  } cfg_reg_e;

  typedef struct packed {
    logic capture_request;
    logic paused;
  } in_word_t;

  typedef struct packed {
    logic forward;
    logic capture_tag;
  } out_word_t;

  typedef struct packed {
    logic            wr;
    logic [IdxW-1:0] index;
    logic [FpsW-1:0] data;
  } cfg_wr_t;

  function automatic logic [FpsW-1:0] sat_fps(logic [FpsW-1:0] value);
    logic [FpsW:0] lim;
    lim = (FpsW+1)'(MaxFps);
    if ({1'b0, value} > lim) begin
      return lim[FpsW-1:0];
    end
    return value;
  endfunction

endpackage

[hdl/frd_core.sv]
// Frame rate decimator: rate registers, frame index, drop count and the
// per-frame drop decision. Depends on frd_pkg.
module frd_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  frd_pkg::cfg_wr_t  cfg_i,
  input  logic              step_i,
  input  frd_pkg::in_word_t item_i,
  output frd_pkg::out_word_t res_o
);
  import frd_pkg::*;

  logic [FpsW-1:0]   cap_q, rec_q;
  logic [FpsW-1:0]   idx_q, idx_d;
  logic [FpsW-1:0]   drop_q, drop_d;
  logic [FpsW-1:0]   rate_c, rate_r, idx_base, drop_base;
  logic              active, drop;
  logic [2*FpsW:0]   lhs, rhs;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CaptureFpsRst;
      rec_q <= RecordFpsRst;
    end else if (cfg_i.wr) begin
      unique case (cfg_i.index)
        RegCaptureFps: cap_q <= sat_fps(cfg_i.data);
        RegRecordFps:  rec_q <= sat_fps(cfg_i.data);
        default: ;
      endcase
    end
  end

  always_comb begin
    rate_c    = cap_q;
    rate_r    = (rec_q > cap_q) ? cap_q : rec_q;
    active    = !item_i.paused || item_i.capture_request;
    idx_base  = (idx_q >= rate_c) ? '0 : idx_q;
    drop_base = (idx_base == '0) ? '0 : drop_q;
    lhs       = ((2*FpsW+1)'(idx_base) + (2*FpsW+1)'(1)) *
                (2*FpsW+1)'(rate_c - rate_r);
    rhs       = (2*FpsW+1)'(rate_c) *
                ((2*FpsW+1)'(drop_base) + (2*FpsW+1)'(1));
    drop      = (rate_c > rate_r) && (lhs >= rhs);
    idx_d     = idx_q;
    drop_d    = drop_q;
    if (active) begin
      idx_d = idx_base + FpsW'(1);
      if (!item_i.capture_request) begin
        drop_d = drop ? drop_base + FpsW'(1) : drop_base;
      end
    end
    res_o.forward     = active && (item_i.capture_request || !drop);
    res_o.capture_tag = active && item_i.capture_request;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q  <= '0;
      drop_q <= '0;
    end else if (step_i) begin
      idx_q  <= idx_d;
      drop_q <= drop_d;
    end
  end

endmodule

[hdl/frame_rate_decimator.sv]
// Frame rate decimator top level: input word register, decision core and
// output word register with stall handshakes. Depends on frd_pkg, frd_core.
//
//   channel | handshake               | word
//   --------+-------------------------+---------------------------------
//   in      | in_valid_i / in_stall_o | in_word_i (capture_request, paused)
//   out     | out_valid_o/ out_stall_i| out_word_o (forward, capture_tag)
//   cfg     | cfg_valid_i/ cfg_ready_o| cfg_index_i, cfg_data_i
//
// One word per cycle unless the output stalls; a word passes both registers.
// The decision runs as the input register hands over to the output register.
// Reset clears the frame index and drop count and loads both rates with 30.
// A stalled output holds its word; the input stalls only when both registers
// are full and the output stalls. Register writes are always taken.
module frame_rate_decimator (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  frd_pkg::in_word_t   in_word_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output frd_pkg::out_word_t  out_word_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [7:0]          cfg_index_i,
  input  logic [6:0]          cfg_data_i
);
  import frd_pkg::*;

  logic      in_valid_q, out_valid_q;
  in_word_t  in_word_q;
  out_word_t out_word_q, res;
  logic      out_free, step, in_take;
  cfg_wr_t   cfg;

  assign cfg_ready_o = 1'b1;
  assign cfg.wr      = cfg_valid_i;
  assign cfg.index   = cfg_index_i;
  assign cfg.data    = cfg_data_i;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign step       = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;
  assign in_take    = in_valid_i && !in_stall_o;

  frd_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .step_i (step),
    .item_i (in_word_q),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_free) begin
        out_valid_q <= in_valid_q;
      end
      if (!in_stall_o) begin
        in_valid_q <= in_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_word_q <= in_word_i;
    end
    if (step) begin
      out_word_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  a_tag_forwarded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (!out_word_o.capture_tag || out_word_o.forward))
    else $error("capture tag on a dropped word");

  a_step_fills_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |=> out_valid_q)
    else $error("decided word lost before output register");

  a_stall_needs_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (in_valid_q && out_valid_q && out_stall_i))
    else $error("input stalled without a full pipeline");

  a_take_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_take |=> in_valid_q)
    else $error("accepted word not held in input register");

endmodule

[test/tb.sv]
// Testbench for frame_rate_decimator: random and directed frame words checked
// against an in-bench decision predictor. Depends on frd_pkg and the RTL only.
`timescale 1ns / 100ps

module tb;
  import frd_pkg::*;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic       in_stall_o;
  in_word_t   in_word_i   = '0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  out_word_t  out_word_o;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  logic [7:0] cfg_index_i = '0;
  logic [6:0] cfg_data_i  = '0;

  in_word_t    frame_q[$];
  out_word_t   verdict_q[$];
  out_word_t   expd;
  bit          word_taken    = 1'b0;
  int unsigned in_idle_pct   = 36;
  int unsigned out_stall_pct = 36;
  int unsigned fails         = 0;

  logic [FpsW-1:0] cap_rate  = CaptureFpsRst;
  logic [FpsW-1:0] rec_rate  = RecordFpsRst;
  logic [FpsW-1:0] frame_pos = '0;
  logic [FpsW-1:0] drop_cnt  = '0;

  logic [6:0] cap_list [10] = '{7'd1, 7'd120, 7'd120, 7'd7, 7'd60,
                                7'd30, 7'd0, 7'd127, 7'd3, 7'd25};
  logic [6:0] rec_list [10] = '{7'd0, 7'd0, 7'd119, 7'd3, 7'd25,
                                7'd30, 7'd5, 7'd127, 7'd100, 7'd24};

  frame_rate_decimator dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #6 clk_i = ~clk_i;

  function automatic logic [FpsW-1:0] clamp_rate(logic [FpsW-1:0] v);
    return (v > MaxFps) ? FpsW'(MaxFps) : v;
  endfunction

  function automatic out_word_t decide_frame(in_word_t w);
    out_word_t   res;
    int unsigned pos;
    int unsigned eff_rec;
    res     = '0;
    eff_rec = (rec_rate > cap_rate) ? cap_rate : rec_rate;
    if (!w.paused || w.capture_request) begin
      if (frame_pos >= cap_rate) begin
        frame_pos = '0;
      end
      pos       = frame_pos;
      frame_pos = frame_pos + 1'b1;
      if (w.capture_request) begin
        res.forward     = 1'b1;
        res.capture_tag = 1'b1;
      end else begin
        if (pos == 0) begin
          drop_cnt = '0;
        end
        if (cap_rate > eff_rec &&
            (pos + 1) * (cap_rate - eff_rec) >= cap_rate * (drop_cnt + 1)) begin
          drop_cnt = drop_cnt + 1'b1;
        end else begin
          res.forward = 1'b1;
        end
      end
    end
    return res;
  endfunction

  // hold a word until taken; idle and stall at random
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || word_taken)) begin
      word_taken = 1'b0;
      if (frame_q.size() != 0 && $urandom_range(99) >= in_idle_pct) begin
        in_valid_i <= 1'b1;
        in_word_i  <= frame_q.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
    out_stall_i <= ($urandom_range(99) < out_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (verdict_q.size() == 0) begin
          fails++;
          $display("%0t: unexpected word: expected none, got forward=%0b tag=%0b",
                   $time, out_word_o.forward, out_word_o.capture_tag);
        end else begin
          expd = verdict_q.pop_front();
          if (out_word_o.forward !== expd.forward) begin
            fails++;
            $display("%0t: forward mismatch: expected %0b, got %0b",
                     $time, expd.forward, out_word_o.forward);
          end
          if (out_word_o.capture_tag !== expd.capture_tag) begin
            fails++;
            $display("%0t: capture_tag mismatch: expected %0b, got %0b",
                     $time, expd.capture_tag, out_word_o.capture_tag);
          end
        end
      end
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          RegCaptureFps: cap_rate = clamp_rate(cfg_data_i);
          RegRecordFps:  rec_rate = clamp_rate(cfg_data_i);
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_o) begin
        verdict_q.push_back(decide_frame(in_word_i));
        word_taken = 1'b1;
      end
    end
  end

  task automatic write_reg(input logic [7:0] idx, input logic [6:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic set_rates(input logic [6:0] cap, input logic [6:0] rec);
    write_reg(RegCaptureFps, cap);
    write_reg(RegRecordFps, rec);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic queue_frame(input logic capture, input logic pause);
    in_word_t w;
    w.capture_request = capture;
    w.paused          = pause;
    frame_q.push_back(w);
  endtask

  task automatic drain();
    while (frame_q.size() != 0 || in_valid_i || verdict_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (4) @(posedge clk_i);
  endtask

  initial begin
    int unsigned n_random;
    int unsigned len;
    int unsigned k;
    n_random = 0;
    k        = 0;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    queue_frame(1'b0, 1'b0);
    queue_frame(1'b1, 1'b0);
    queue_frame(1'b0, 1'b1);
    queue_frame(1'b1, 1'b1);
    drain();

    write_reg(8'(RegRecordFps) + 8'd1, 7'h55);
    write_reg('1, 7'h2A);
    set_rates(7'd5, 7'd2);
    repeat (6) queue_frame(1'b0, 1'b0);
    queue_frame(1'b1, 1'b0);
    queue_frame(1'b1, 1'b1);
    queue_frame(1'b0, 1'b1);
    repeat (2) queue_frame(1'b0, 1'b0);
    drain();

    set_rates(7'd0, 7'd127);
    repeat (3) queue_frame(1'b0, 1'b0);
    queue_frame(1'b1, 1'b0);
    drain();

    set_rates(7'd127, 7'd0);
    repeat (4) queue_frame(1'b0, 1'b0);
    queue_frame(1'b0, 1'b1);
    drain();

    while (n_random < 950) begin
      if ($urandom_range(3) == 0) begin
        write_reg(8'($urandom_range(255, int'(RegRecordFps) + 1)),
                  7'($urandom_range(127)));
      end
      if (k < 10) begin
        set_rates(cap_list[k], rec_list[k]);
      end else begin
        set_rates(7'($urandom_range(127)), 7'($urandom_range(127)));
      end
      in_idle_pct   = (k == 3) ? 0 : 36;
      out_stall_pct = (k == 3) ? 0 : 36;
      len = (k == 3) ? 200 : $urandom_range(140, 40);
      repeat (len) queue_frame($urandom_range(99) < 10, $urandom_range(99) < 12);
      n_random += len;
      k++;
      drain();
    end

    if (fails == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
